FILE: hdl/ikc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared types, codes and constants of the interrupted-key cipher.
// ----------------------------------------------------------------------------
package ikc_pkg;

  localparam int MaxKeyLetters = 24;
  localparam int LetterW       = 5;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 60;
  localparam int LettersPerWord = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LOW  = 3'd0,
    REG_KEY_HIGH = 3'd1,
    REG_KEY_LEN  = 3'd2,
    REG_BASE     = 3'd3,
    REG_DIR      = 3'd4,
    REG_SOURCE   = 3'd5,
    REG_INTR     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BASE_VIGENERE = 2'd0,
    BASE_VARIANT  = 2'd1,
    BASE_BEAUFORT = 2'd2
  } base_cipher_e;

  typedef enum logic [1:0] {
    SRC_FLAG   = 2'd0,
    SRC_PLAIN  = 2'd1,
    SRC_CIPHER = 2'd2
  } break_source_e;

  typedef struct packed {
    logic [LetterW-1:0] in_letter;
    logic               break_here;
    logic               start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] out_letter;
    logic [LetterW-1:0] key_slot;
  } out_item_t;

  typedef struct packed {
    logic [LetterW-1:0] key_length;
    logic [1:0]         base_cipher;
    logic               direction;
    logic [1:0]         break_source;
    logic [LetterW-1:0] interruptor_letter;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/interrupted_key_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interrupted_key_cipher
// Interrupted-key Vigenere / Variant / Beaufort cipher, one letter per item.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while in_ready_o is high. On its way the
// item lands in an input register, the key letter pick, mod-26 shift and key
// index update are combinational, and the result waits in an output register.
// Ready drops only when both registers are full and the output is stalled.
// Configuration writes are always taken (cfg_ready_o is high) and must be
// issued only while no item is in flight.
module interrupted_key_cipher #(
  parameter int MAX_KEY_LETTERS = ikc_pkg::MaxKeyLetters
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ikc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ikc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ikc_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ikc_pkg::out_item_t            out_item_o
);

  logic [MAX_KEY_LETTERS-1:0][ikc_pkg::LetterW-1:0] key_letters;
  ikc_pkg::cfg_t                                    cfg;

  assign cfg_ready_o = 1'b1;

  ikc_cfg #(
    .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .key_letters_o(key_letters),
    .cfg_o        (cfg)
  );

  ikc_core #(
    .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_letters_i(key_letters),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

FILE: hdl/ikc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikc_cfg
// Configuration registers: keyword letters and mode settings.
// ----------------------------------------------------------------------------
module ikc_cfg #(
  parameter int MAX_KEY_LETTERS = ikc_pkg::MaxKeyLetters
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_valid_i,
  input  logic [ikc_pkg::CfgIdxW-1:0]                    cfg_index_i,
  input  logic [ikc_pkg::CfgDataW-1:0]                   cfg_data_i,
  output logic [MAX_KEY_LETTERS-1:0][ikc_pkg::LetterW-1:0] key_letters_o,
  output ikc_pkg::cfg_t                                  cfg_o
);

  ikc_pkg::cfg_t cfg_q;

  for (genvar i = 0; i < MAX_KEY_LETTERS; i++) begin : g_letter
    localparam int Pos = (i % ikc_pkg::LettersPerWord) * ikc_pkg::LetterW;
    localparam ikc_pkg::cfg_reg_e Reg =
      (i < ikc_pkg::LettersPerWord) ? ikc_pkg::REG_KEY_LOW : ikc_pkg::REG_KEY_HIGH;
    logic [ikc_pkg::LetterW-1:0] letter_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        letter_q <= '0;
      end else if (cfg_valid_i && (cfg_index_i == Reg)) begin
        letter_q <= cfg_data_i[Pos +: ikc_pkg::LetterW];
      end
    end

    assign key_letters_o[i] = letter_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        key_length:         ikc_pkg::LetterW'(1),
        base_cipher:        2'd0,
        direction:          1'b0,
        break_source:       2'd0,
        interruptor_letter: '0
      };
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ikc_pkg::REG_KEY_LEN: cfg_q.key_length <= cfg_data_i[ikc_pkg::LetterW-1:0];
        ikc_pkg::REG_BASE:    cfg_q.base_cipher <= cfg_data_i[1:0];
        ikc_pkg::REG_DIR:     cfg_q.direction <= cfg_data_i[0];
        ikc_pkg::REG_SOURCE:  cfg_q.break_source <= cfg_data_i[1:0];
        ikc_pkg::REG_INTR:    cfg_q.interruptor_letter <= cfg_data_i[ikc_pkg::LetterW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/ikc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ikc_core
// Input register, key index, mod-26 shift and result register.
// ----------------------------------------------------------------------------
module ikc_core #(
  parameter int MAX_KEY_LETTERS = ikc_pkg::MaxKeyLetters
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [MAX_KEY_LETTERS-1:0][ikc_pkg::LetterW-1:0] key_letters_i,
  input  ikc_pkg::cfg_t                                  cfg_i,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  ikc_pkg::in_item_t                              in_item_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output ikc_pkg::out_item_t                             out_item_o
);

  localparam int W = ikc_pkg::LetterW;
  localparam int IdxW = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
  localparam logic [W-1:0] MaxLen = W'(MAX_KEY_LETTERS);
  localparam logic [W-1:0] Alpha  = W'(26);

  function automatic logic [W-1:0] red26(logic [W-1:0] v);
    return (v >= Alpha) ? W'(v - Alpha) : v;
  endfunction

  function automatic logic [W-1:0] add26(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, Alpha}) ? W'(s - {1'b0, Alpha}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub26(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, Alpha} - {1'b0, b};
    return (a >= b) ? W'(a - b) : s[W-1:0];
  endfunction

  logic               in_valid_q;
  ikc_pkg::in_item_t  in_item_q;
  logic               out_valid_q;
  ikc_pkg::out_item_t out_item_q;
  logic [W-1:0]       key_index_q, key_index_d;
  ikc_pkg::out_item_t out_item_d;

  logic         adv;
  logic         supplied, dec;
  logic [W-1:0] len_eff, letter, slot, k, res, plain, cipher, trigger, slot_inc;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || adv;

  always_comb begin
    supplied = !((cfg_i.break_source == ikc_pkg::SRC_PLAIN) ||
                 (cfg_i.break_source == ikc_pkg::SRC_CIPHER));
    dec      = cfg_i.direction;

    len_eff = cfg_i.key_length;
    if (len_eff == '0) len_eff = W'(1);
    if (len_eff > MaxLen) len_eff = MaxLen;

    letter = red26(in_item_q.in_letter);
    slot   = (key_index_q >= len_eff) ? '0 : key_index_q;
    if (in_item_q.start_of_text || (supplied && in_item_q.break_here)) slot = '0;

    k = red26(key_letters_i[slot[IdxW-1:0]]);

    case (cfg_i.base_cipher)
      ikc_pkg::BASE_BEAUFORT: res = sub26(k, letter);
      ikc_pkg::BASE_VARIANT:  res = dec ? add26(letter, k) : sub26(letter, k);
      default:                res = dec ? sub26(letter, k) : add26(letter, k);
    endcase

    plain   = dec ? res : letter;
    cipher  = dec ? letter : res;
    trigger = (cfg_i.break_source == ikc_pkg::SRC_PLAIN) ? plain : cipher;

    slot_inc = W'(slot + W'(1));
    if (!supplied && (trigger == cfg_i.interruptor_letter)) begin
      key_index_d = '0;
    end else begin
      key_index_d = (slot_inc >= len_eff) ? '0 : slot_inc;
    end

    out_item_d.out_letter = res;
    out_item_d.key_slot   = slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_index_q <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv) out_valid_q <= in_valid_q;
      if (adv && in_valid_q) key_index_q <= key_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_item_i;
    if (adv && in_valid_q) out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_index_q < MaxLen)
    else $error("key index beyond key storage");

  a_out_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.out_letter < Alpha))
    else $error("result letter out of alphabet");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.key_slot < MaxLen))
    else $error("result key slot beyond key storage");

  a_start_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_valid_q && in_item_q.start_of_text) |=> (out_item_q.key_slot == '0))
    else $error("start of text did not restart the key");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/ikc_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_cipher_checker
// Watches the configuration, input and result channels of the interrupted-key
// cipher. It keeps its own copy of the registers and the key position, works
// out the letter and key slot of every accepted input item, and compares each
// accepted result with the oldest outstanding prediction. It reports the
// number of failures and of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module ikc_cipher_checker
  import ikc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [CfgDataW-1:0] key_word_lo;
  logic [CfgDataW-1:0] key_word_hi;
  logic [LetterW-1:0]  key_len;
  logic [1:0]          base_sel;
  logic                decrypt;
  logic [1:0]          break_src;
  logic [LetterW-1:0]  interruptor;
  logic [LetterW-1:0]  key_pos;
  out_item_t           expected_letters[$];

  function automatic out_item_t encipher_next(in_item_t it);
    int                  letter;
    int                  len;
    int                  slot;
    int                  k;
    int                  res;
    int                  trigger;
    int                  nxt;
    logic [CfgDataW-1:0] word;
    logic                supplied;
    out_item_t           r;
    letter = int'(it.in_letter) % 26;
    len = (key_len == '0) ? 1 : int'(key_len);
    if (len > MaxKeyLetters) len = MaxKeyLetters;
    supplied = (break_src != SRC_PLAIN) && (break_src != SRC_CIPHER);
    slot = (int'(key_pos) >= len) ? 0 : int'(key_pos);
    if (it.start_of_text || (supplied && it.break_here)) slot = 0;
    word = (slot < LettersPerWord) ? key_word_lo : key_word_hi;
    k = int'(word[(slot % LettersPerWord) * LetterW +: LetterW]) % 26;
    case (base_sel)
      BASE_BEAUFORT: res = (k - letter + 26) % 26;
      BASE_VARIANT:  res = decrypt ? (letter + k) % 26 : (letter - k + 26) % 26;
      default:       res = decrypt ? (letter - k + 26) % 26 : (letter + k) % 26;
    endcase
    if (break_src == SRC_PLAIN) trigger = decrypt ? res : letter;
    else trigger = decrypt ? letter : res;
    if (!supplied && trigger == int'(interruptor)) nxt = 0;
    else nxt = (slot + 1 >= len) ? 0 : slot + 1;
    key_pos = LetterW'(nxt);
    r.out_letter = LetterW'(res);
    r.key_slot = LetterW'(slot);
    return r;
  endfunction

  // sample mid-cycle: every channel is stable until the next rising edge
  always @(negedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      key_word_lo = '0;
      key_word_hi = '0;
      key_len = 5'd1;
      base_sel = BASE_VIGENERE;
      decrypt = 1'b0;
      break_src = SRC_FLAG;
      interruptor = '0;
      key_pos = '0;
      expected_letters.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_KEY_LOW:  key_word_lo = cfg_data_i;
          REG_KEY_HIGH: key_word_hi = cfg_data_i;
          REG_KEY_LEN:  key_len = cfg_data_i[LetterW-1:0];
          REG_BASE:     base_sel = cfg_data_i[1:0];
          REG_DIR:      decrypt = cfg_data_i[0];
          REG_SOURCE:   break_src = cfg_data_i[1:0];
          REG_INTR:     interruptor = cfg_data_i[LetterW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_letters.push_back(encipher_next(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_letters.size() == 0) begin
          $error("unexpected result: out_letter %0d, key_slot %0d",
                 out_item_i.out_letter, out_item_i.key_slot);
          fail_count_o++;
        end else begin
          want = expected_letters.pop_front();
          if (out_item_i.out_letter !== want.out_letter) begin
            $error("out_letter: expected %0d, actual %0d",
                   want.out_letter, out_item_i.out_letter);
            fail_count_o++;
          end
          if (out_item_i.key_slot !== want.key_slot) begin
            $error("key_slot: expected %0d, actual %0d",
                   want.key_slot, out_item_i.key_slot);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_letters.size();
    end
  end

endmodule

FILE: tb/sv/tb_interrupted_key_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interrupted_key_cipher
// Stimulus and verdict for the interrupted-key cipher. A short directed run
// covers the letter and register extremes, every base shift and direction,
// every break source and the unused codes; random phases then reprogram the
// key between bursts of texts under three idling regimes, with one long
// result stall. Prediction and checking sit in ikc_cipher_checker.
// ----------------------------------------------------------------------------
module tb_interrupted_key_cipher;
  import ikc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused  = 3'd7;
  localparam logic [1:0]         BaseUnused = 2'd3;
  localparam logic [1:0]         SrcUnused  = 2'd3;
  localparam logic               DirEncrypt = 1'b0;
  localparam logic               DirDecrypt = 1'b1;
  localparam int                 HoldCycles = 40;
  localparam int                 PhaseItems = 180;
  localparam int                 TimeoutNs  = 1_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  int                  fail_count;
  int                  pending;

  int                  send_idle_pct = 11;
  int                  recv_idle_pct = 53;
  bit                  hold_req = 1'b0;
  logic [LetterW-1:0]  cur_intr = '0;

  interrupted_key_cipher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  ikc_cipher_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(TimeoutNs);
    $display("interrupted_key_cipher regression: fail");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [CfgDataW-1:0] rand60();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CfgDataW-1:0];
  endfunction

  function automatic in_item_t letter_in(int letter, bit brk, bit start);
    in_item_t it;
    it.in_letter = LetterW'(letter);
    it.break_here = brk;
    it.start_of_text = start;
    return it;
  endfunction

  function automatic in_item_t text_letter();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 5) it.in_letter = LetterW'($urandom_range(31, 26));
    else if (pick < 20) it.in_letter = cur_intr;
    else it.in_letter = LetterW'($urandom_range(25));
    it.break_here = ($urandom_range(99) < 10);
    it.start_of_text = 1'b0;
    return it;
  endfunction

  // hold cfg_valid high across back-to-back writes
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic setup(logic [CfgDataW-1:0] klo, logic [CfgDataW-1:0] khi,
                       logic [LetterW-1:0] len, logic [1:0] base, logic dir,
                       logic [1:0] src, logic [LetterW-1:0] intr);
    write_reg(REG_KEY_LOW, klo);
    write_reg(REG_KEY_HIGH, khi);
    write_reg(REG_KEY_LEN, (rand60() << LetterW) | CfgDataW'(len));
    write_reg(REG_BASE, (rand60() << 2) | CfgDataW'(base));
    write_reg(REG_DIR, (rand60() << 1) | CfgDataW'(dir));
    write_reg(REG_SOURCE, (rand60() << 2) | CfgDataW'(src));
    write_reg(REG_INTR, (rand60() << LetterW) | CfgDataW'(intr));
    write_reg(RegUnused, rand60());
    cfg_valid <= 1'b0;
    cur_intr = intr;
  endtask

  task automatic random_setup();
    logic [LetterW-1:0] len;
    logic [LetterW-1:0] intr;
    int                 pick;
    pick = $urandom_range(19);
    if (pick == 0) len = '0;
    else if (pick == 1) len = LetterW'($urandom_range(31, 25));
    else if (pick < 5) len = LetterW'(MaxKeyLetters);
    else len = LetterW'($urandom_range(23, 1));
    if ($urandom_range(99) < 85) intr = LetterW'($urandom_range(25));
    else intr = LetterW'($urandom_range(31, 26));
    setup(rand60(), rand60(), len, 2'($urandom_range(3)), 1'($urandom_range(1)),
          2'($urandom_range(3)), intr);
  endtask

  // keep valid high between items unless a gap is taken
  task automatic send_item(in_item_t it);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    in_item_t it;
    int       sent;
    int       run_len;
    int       n;
    int       text_len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    setup('1, '0, 5'd31, BASE_VIGENERE, DirEncrypt, SRC_FLAG, 5'd0);
    send_item(letter_in(0, 1'b0, 1'b0));
    send_item(letter_in(25, 1'b0, 1'b0));
    send_item(letter_in(26, 1'b0, 1'b0));
    send_item(letter_in(31, 1'b1, 1'b0));
    send_item(letter_in(13, 1'b0, 1'b0));
    send_item(letter_in(7, 1'b0, 1'b0));
    drain_results();
    setup(60'h0123_4567_89AB_CDE, '1, 5'd2, BASE_VARIANT, DirDecrypt, SrcUnused, 5'd4);
    send_item(letter_in(5, 1'b0, 1'b0));
    send_item(letter_in(26, 1'b1, 1'b0));
    send_item(letter_in(31, 1'b1, 1'b1));
    send_item(letter_in(0, 1'b0, 1'b1));
    drain_results();
    setup(60'hFED_CBA9_8765_4321, '0, 5'd5, BASE_BEAUFORT, DirEncrypt, SRC_PLAIN, 5'd3);
    send_item(letter_in(3, 1'b1, 1'b0));
    send_item(letter_in(9, 1'b0, 1'b0));
    send_item(letter_in(3, 1'b0, 1'b0));
    send_item(letter_in(31, 1'b1, 1'b1));
    drain_results();
    setup(rand60(), rand60(), 5'd0, BaseUnused, DirDecrypt, SRC_CIPHER, 5'd0);
    send_item(letter_in(0, 1'b1, 1'b0));
    send_item(letter_in(25, 1'b0, 1'b0));
    send_item(letter_in(28, 1'b0, 1'b1));
    send_item(letter_in(0, 1'b0, 1'b0));
    drain_results();
    setup('0, '1, 5'd24, BASE_VIGENERE, DirDecrypt, SRC_CIPHER, 5'd29);
    send_item(letter_in(29, 1'b0, 1'b0));
    send_item(letter_in(3, 1'b1, 1'b0));
    send_item(letter_in(12, 1'b0, 1'b0));
    drain_results();
    setup(rand60(), rand60(), 5'd13, BASE_VARIANT, DirEncrypt, SRC_PLAIN, 5'd25);
    send_item(letter_in(25, 1'b0, 1'b1));
    send_item(letter_in(1, 1'b0, 1'b0));
    send_item(letter_in(30, 1'b1, 1'b0));

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        drain_results();
        random_setup();
        if (regime == 2 && sent == 0) hold_req = 1'b1;
        run_len = $urandom_range(50, 15);
        n = 0;
        while (n < run_len) begin
          text_len = $urandom_range(24, 1);
          for (int i = 0; i < text_len && n < run_len; i++) begin
            if ($urandom_range(9) == 0) begin
              it = in_item_t'(7'($urandom));
            end else begin
              it = text_letter();
              it.start_of_text = (i == 0) && ($urandom_range(9) != 0);
            end
            send_item(it);
            n++;
            if ($urandom_range(99) == 0) drain_results();
          end
        end
        sent += run_len;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("interrupted_key_cipher regression: pass");
    end else begin
      $display("interrupted_key_cipher regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ikc_pkg.sv
hdl/ikc_cfg.sv
hdl/ikc_core.sv
hdl/interrupted_key_cipher.sv
tb/sv/ikc_cipher_checker.sv
tb/sv/tb_interrupted_key_cipher.sv
